// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file; no dependencies
// each takes a label, clock, active-low reset (not the last) and two expressions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off during reset
`define PRGB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("prgb assertion failed");

// implication into the next cycle, off during reset
`define PRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("prgb assertion failed");

// implication into the next cycle, live during reset too
`define PRGB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("prgb assertion failed");

`endif

// ===== hw/rtl/prgb_pkg.sv =====
// types, register codes and constants of the packed rgb to gray argb block
// no dependencies; used by every module of the block but prgb_ram
package prgb_pkg;

    localparam int unsigned NUM_CH    = 3;
    localparam int unsigned CH_RED    = 0;
    localparam int unsigned CH_GREEN  = 1;
    localparam int unsigned CH_BLUE   = 2;
    localparam int unsigned LUT_DEPTH = 256;
    localparam int unsigned LUT_AW    = 8;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned SUM_W     = 18;

    localparam logic [9:0]  WEIGHT_R    = 10'd299;
    localparam logic [9:0]  WEIGHT_G    = 10'd587;
    localparam logic [9:0]  WEIGHT_B    = 10'd114;
    // floor(x / 1000) = floor((x >> 3) / 125) = ((x >> 3) * RECIP_125) >> RECIP_SHIFT
    localparam logic [15:0] RECIP_125   = 16'd33555;
    localparam int unsigned RECIP_SHIFT = 22;
    localparam logic [7:0]  CHANNEL_TOP = 8'd255;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [2:0] {
        REG_PIXEL_SIZE_MODE  = 3'd0,
        REG_RED_POSITION     = 3'd1,
        REG_GREEN_POSITION   = 3'd2,
        REG_BLUE_POSITION    = 3'd3,
        REG_RED_FULL_SCALE   = 3'd4,
        REG_GREEN_FULL_SCALE = 3'd5,
        REG_BLUE_FULL_SCALE  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        SIZE_8  = 2'd0,
        SIZE_16 = 2'd1,
        SIZE_32 = 2'd2
    } t_size_mode;

    typedef enum logic [1:0] {
        BLD_DIV,
        BLD_FILL,
        BLD_DONE
    } t_bld_state;

    typedef struct packed {
        logic [1:0]                  pixel_size_mode;
        logic [NUM_CH-1:0][4:0]      position;
        logic [NUM_CH-1:0][CFG_W-1:0] full_scale;
    } t_cfg;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic        line_end;
        logic        frame_end;
    } t_pix_in;

    typedef struct packed {
        logic [31:0] gray_argb;
        logic        line_end_out;
        logic        frame_end_out;
    } t_gray_out;

    typedef struct packed {
        logic                        en;
        logic [LUT_AW-1:0]           addr;
        logic [NUM_CH-1:0][CH_W-1:0] data;
    } t_tbl_wr;

    localparam logic [1:0]       RST_SIZE_MODE  = 2'd2;
    localparam logic [4:0]       RST_RED_POS    = 5'd16;
    localparam logic [4:0]       RST_GREEN_POS  = 5'd8;
    localparam logic [4:0]       RST_BLUE_POS   = 5'd0;
    localparam logic [CFG_W-1:0] RST_FULL_SCALE = 16'd255;

endpackage

// ===== hw/rtl/prgb_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module prgb_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== hw/rtl/prgb_cfg.sv =====
// configuration registers and table rebuild request
// depends on prgb_pkg
module prgb_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [prgb_pkg::CFG_W-1:0] i_cfg_wdata,
    output prgb_pkg::t_cfg             o_cfg,
    output logic                       o_rebuild
);

    prgb_pkg::t_cfg r_cfg;
    prgb_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg     = r_cfg;
        o_rebuild = 1'b0;
        if (i_cfg_we) begin
            case (prgb_pkg::t_reg_idx'(i_cfg_index))
                prgb_pkg::REG_PIXEL_SIZE_MODE: begin
                    n_cfg.pixel_size_mode = i_cfg_wdata[1:0];
                end
                prgb_pkg::REG_RED_POSITION: begin
                    n_cfg.position[prgb_pkg::CH_RED] = i_cfg_wdata[4:0];
                end
                prgb_pkg::REG_GREEN_POSITION: begin
                    n_cfg.position[prgb_pkg::CH_GREEN] = i_cfg_wdata[4:0];
                end
                prgb_pkg::REG_BLUE_POSITION: begin
                    n_cfg.position[prgb_pkg::CH_BLUE] = i_cfg_wdata[4:0];
                end
                prgb_pkg::REG_RED_FULL_SCALE: begin
                    n_cfg.full_scale[prgb_pkg::CH_RED] = i_cfg_wdata;
                    o_rebuild = 1'b1;
                end
                prgb_pkg::REG_GREEN_FULL_SCALE: begin
                    n_cfg.full_scale[prgb_pkg::CH_GREEN] = i_cfg_wdata;
                    o_rebuild = 1'b1;
                end
                prgb_pkg::REG_BLUE_FULL_SCALE: begin
                    n_cfg.full_scale[prgb_pkg::CH_BLUE] = i_cfg_wdata;
                    o_rebuild = 1'b1;
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_size_mode                 <= prgb_pkg::RST_SIZE_MODE;
            r_cfg.position[prgb_pkg::CH_RED]      <= prgb_pkg::RST_RED_POS;
            r_cfg.position[prgb_pkg::CH_GREEN]    <= prgb_pkg::RST_GREEN_POS;
            r_cfg.position[prgb_pkg::CH_BLUE]     <= prgb_pkg::RST_BLUE_POS;
            r_cfg.full_scale[prgb_pkg::CH_RED]    <= prgb_pkg::RST_FULL_SCALE;
            r_cfg.full_scale[prgb_pkg::CH_GREEN]  <= prgb_pkg::RST_FULL_SCALE;
            r_cfg.full_scale[prgb_pkg::CH_BLUE]   <= prgb_pkg::RST_FULL_SCALE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/prgb_build.sv =====
// channel scaling table builder: 255 / full_scale by restoring division, then a sweep
// writing floor(i * 255 / full_scale) for every index; depends on prgb_pkg
module prgb_build (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prgb_pkg::t_cfg      i_cfg,
    input  logic                i_rebuild,
    output prgb_pkg::t_tbl_wr   o_wr,
    output logic                o_busy
);

    prgb_pkg::t_bld_state r_state;
    prgb_pkg::t_bld_state n_state;

    logic [2:0]                                  r_step;
    logic [2:0]                                  n_step;
    logic [prgb_pkg::LUT_AW-1:0]                 r_idx;
    logic [prgb_pkg::LUT_AW-1:0]                 n_idx;
    logic [prgb_pkg::NUM_CH-1:0][7:0]            r_quo;
    logic [prgb_pkg::NUM_CH-1:0][7:0]            n_quo;
    logic [prgb_pkg::NUM_CH-1:0][7:0]            r_rem;
    logic [prgb_pkg::NUM_CH-1:0][7:0]            n_rem;
    logic [prgb_pkg::NUM_CH-1:0][7:0]            r_acc_q;
    logic [prgb_pkg::NUM_CH-1:0][7:0]            n_acc_q;
    logic [prgb_pkg::NUM_CH-1:0][7:0]            r_acc_r;
    logic [prgb_pkg::NUM_CH-1:0][7:0]            n_acc_r;

    logic [prgb_pkg::NUM_CH-1:0]                 w_fs_ok;
    logic [prgb_pkg::NUM_CH-1:0][8:0]            w_fs9;
    logic [prgb_pkg::NUM_CH-1:0][8:0]            w_trial;
    logic [prgb_pkg::NUM_CH-1:0]                 w_trial_ge;
    logic [prgb_pkg::NUM_CH-1:0][8:0]            w_acc_sum;
    logic [prgb_pkg::NUM_CH-1:0]                 w_acc_ge;
    logic [prgb_pkg::NUM_CH-1:0][8:0]            w_acc_sub;

    // per channel arithmetic
    always_comb begin
        for (int c = 0; c < prgb_pkg::NUM_CH; c++) begin
            w_fs_ok[c]    = (i_cfg.full_scale[c] != '0) &&
                            (i_cfg.full_scale[c][prgb_pkg::CFG_W-1:8] == '0);
            w_fs9[c]      = {1'b0, i_cfg.full_scale[c][7:0]};
            w_trial[c]    = {r_rem[c], 1'b1};
            w_trial_ge[c] = (w_trial[c] >= w_fs9[c]);
            w_acc_sum[c]  = {1'b0, r_acc_r[c]} + {1'b0, r_rem[c]};
            w_acc_ge[c]   = (w_acc_sum[c] >= w_fs9[c]);
            w_acc_sub[c]  = w_acc_sum[c] - w_fs9[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prgb_pkg::BLD_DIV;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_idx   = r_idx;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_acc_q = r_acc_q;
        n_acc_r = r_acc_r;
        o_wr.en   = 1'b0;
        o_wr.addr = r_idx;
        for (int c = 0; c < prgb_pkg::NUM_CH; c++) begin
            o_wr.data[c] = w_fs_ok[c] ? r_acc_q[c] : '0;
        end
        case (r_state)
            prgb_pkg::BLD_DIV: begin
                for (int c = 0; c < prgb_pkg::NUM_CH; c++) begin
                    n_quo[c] = {r_quo[c][6:0], w_trial_ge[c]};
                    n_rem[c] = w_trial_ge[c] ? 8'(w_trial[c] - w_fs9[c]) : w_trial[c][7:0];
                end
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_state = prgb_pkg::BLD_FILL;
                    n_idx   = '0;
                    n_acc_q = '0;
                    n_acc_r = '0;
                end
            end
            prgb_pkg::BLD_FILL: begin
                o_wr.en = 1'b1;
                for (int c = 0; c < prgb_pkg::NUM_CH; c++) begin
                    n_acc_q[c] = r_acc_q[c] + r_quo[c] + {7'd0, w_acc_ge[c]};
                    n_acc_r[c] = w_acc_ge[c] ? w_acc_sub[c][7:0] : w_acc_sum[c][7:0];
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == prgb_pkg::LUT_AW'(prgb_pkg::LUT_DEPTH - 1)) begin
                    n_state = prgb_pkg::BLD_DONE;
                end
            end
            prgb_pkg::BLD_DONE: begin
                n_state = prgb_pkg::BLD_DONE;
            end
            default: begin
                n_state = prgb_pkg::BLD_DIV;
            end
        endcase
        // a new full scale restarts the whole build
        if (i_rebuild) begin
            n_state = prgb_pkg::BLD_DIV;
            n_step  = '0;
            n_quo   = '0;
            n_rem   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_idx   <= '0;
            r_quo   <= '0;
            r_rem   <= '0;
            r_acc_q <= '0;
            r_acc_r <= '0;
        end else begin
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_quo   <= n_quo;
            r_rem   <= n_rem;
            r_acc_q <= n_acc_q;
            r_acc_r <= n_acc_r;
        end
    end

    assign o_busy = (r_state != prgb_pkg::BLD_DONE);

endmodule

// ===== hw/rtl/prgb_datapath.sv =====
// pixel pipeline: channel extraction and table read, weighted luma sum, divide by 1000
// and output register; depends on prgb_pkg, reads the tables built by prgb_build
module prgb_datapath (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  prgb_pkg::t_cfg                                 i_cfg,
    input  logic                                           i_busy,
    input  logic                                           i_in_valid,
    input  prgb_pkg::t_pix_in                              i_in_data,
    output logic                                           o_in_stall,
    output logic                                           o_lut_re,
    output logic [prgb_pkg::NUM_CH-1:0][prgb_pkg::LUT_AW-1:0] o_lut_raddr,
    input  logic [prgb_pkg::NUM_CH-1:0][prgb_pkg::CH_W-1:0]   i_lut_rdata,
    output logic                                           o_out_valid,
    output prgb_pkg::t_gray_out                            o_out_data,
    input  logic                                           i_out_stall
);

    logic                              r_b_valid;
    logic [1:0]                        r_b_flags;
    logic                              r_s_valid;
    logic [1:0]                        r_s_flags;
    logic [prgb_pkg::SUM_W-1:0]        r_s_sum;
    logic                              r_o_valid;
    prgb_pkg::t_gray_out               r_o_data;

    logic                              w_en_o;
    logic                              w_en_s;
    logic                              w_en_b;
    logic                              w_accept;
    logic [31:0]                       w_pix;
    logic [prgb_pkg::NUM_CH-1:0][31:0] w_shifted;
    logic [prgb_pkg::SUM_W-1:0]        w_sum;
    logic [14:0]                       w_div_x;
    logic [30:0]                       w_prod;
    logic [7:0]                        w_gray;

    assign w_en_o     = !r_o_valid || !i_out_stall;
    assign w_en_s     = !r_s_valid || w_en_o;
    assign w_en_b     = !r_b_valid || w_en_s;
    assign o_in_stall = !w_en_b || i_busy;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_lut_re   = w_accept;

    // pixel size cut and channel extraction
    always_comb begin
        case (i_cfg.pixel_size_mode)
            prgb_pkg::SIZE_16: w_pix = {16'd0, i_in_data.pixel_word[15:0]};
            prgb_pkg::SIZE_32: w_pix = i_in_data.pixel_word;
            default:           w_pix = {24'd0, i_in_data.pixel_word[7:0]};
        endcase
        for (int c = 0; c < prgb_pkg::NUM_CH; c++) begin
            w_shifted[c]   = w_pix >> i_cfg.position[c];
            o_lut_raddr[c] = w_shifted[c][7:0] & i_cfg.full_scale[c][7:0];
        end
    end

    assign w_sum =
        ({10'd0, i_lut_rdata[prgb_pkg::CH_RED]}   * {8'd0, prgb_pkg::WEIGHT_R}) +
        ({10'd0, i_lut_rdata[prgb_pkg::CH_GREEN]} * {8'd0, prgb_pkg::WEIGHT_G}) +
        ({10'd0, i_lut_rdata[prgb_pkg::CH_BLUE]}  * {8'd0, prgb_pkg::WEIGHT_B});

    assign w_div_x = r_s_sum[prgb_pkg::SUM_W-1:3];
    assign w_prod  = {16'd0, w_div_x} * {15'd0, prgb_pkg::RECIP_125};
    assign w_gray  = w_prod[prgb_pkg::RECIP_SHIFT+7:prgb_pkg::RECIP_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_en_b) begin
                r_b_valid <= w_accept;
            end
            if (w_en_s) begin
                r_s_valid <= r_b_valid;
            end
            if (w_en_o) begin
                r_o_valid <= r_s_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_flags <= {i_in_data.line_end, i_in_data.frame_end};
        end
        if (w_en_s && r_b_valid) begin
            r_s_sum   <= w_sum;
            r_s_flags <= r_b_flags;
        end
        if (w_en_o && r_s_valid) begin
            r_o_data.gray_argb     <= {prgb_pkg::ALPHA_OPAQUE, w_gray, w_gray, w_gray};
            r_o_data.line_end_out  <= r_s_flags[1];
            r_o_data.frame_end_out <= r_s_flags[0];
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

// ===== hw/rtl/packed_rgb_to_gray_argb_top.sv =====
// top level of the packed rgb to gray argb converter
// depends on prgb_pkg, prgb_cfg, prgb_build, prgb_ram and prgb_datapath
//
// Converts one packed pixel per clock into an opaque gray ARGB word while the output
// keeps up and no table rebuild runs. Each transaction on the input is answered by
// exactly one output transaction through the table read, sum and output registers, and
// the output register lets the input go on while a result waits. Channel scaling comes
// from three 256-entry tables, one per channel, rebuilt by a sweep through their single
// write port after reset and after every write to a full-scale register, during which
// the input is stalled. Line-end and frame-end marks travel with the pixel.
module packed_rgb_to_gray_argb_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  prgb_pkg::t_pix_in          i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output prgb_pkg::t_gray_out        o_out_data,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [prgb_pkg::CFG_W-1:0] i_cfg_wdata
);

    prgb_pkg::t_cfg    w_cfg;
    logic              w_rebuild;
    prgb_pkg::t_tbl_wr w_wr;
    logic              w_busy;
    logic              w_lut_re;
    logic [prgb_pkg::NUM_CH-1:0][prgb_pkg::LUT_AW-1:0] w_lut_raddr;
    logic [prgb_pkg::NUM_CH-1:0][prgb_pkg::CH_W-1:0]   w_lut_rdata;

    prgb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg),
        .o_rebuild   (w_rebuild)
    );

    prgb_build u_build (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_rebuild (w_rebuild),
        .o_wr      (w_wr),
        .o_busy    (w_busy)
    );

    for (genvar c = 0; c < prgb_pkg::NUM_CH; c++) begin : g_lut
        prgb_ram #(
            .DEPTH (prgb_pkg::LUT_DEPTH),
            .WIDTH (prgb_pkg::CH_W)
        ) u_lut (
            .i_clk   (i_clk),
            .i_we    (w_wr.en),
            .i_waddr (w_wr.addr),
            .i_wdata (w_wr.data[c]),
            .i_re    (w_lut_re),
            .i_raddr (w_lut_raddr[c]),
            .o_rdata (w_lut_rdata[c])
        );
    end

    prgb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_busy      (w_busy),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_lut_re    (w_lut_re),
        .o_lut_raddr (w_lut_raddr),
        .i_lut_rdata (w_lut_rdata),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== hw/rtl/prgb_checker.sv =====
// port-level checker for the packed rgb to gray argb top, bound to it below
// depends on prgb_pkg and assert_macros.svh
`include "assert_macros.svh"

module prgb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input prgb_pkg::t_pix_in          i_in_data,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input prgb_pkg::t_gray_out        o_out_data,
    input logic                       i_out_stall,
    input logic                       i_cfg_we,
    input logic [2:0]                 i_cfg_index,
    input logic [prgb_pkg::CFG_W-1:0] i_cfg_wdata
);

    logic w_fs_write;
    logic w_gray_same;

    assign w_fs_write = i_cfg_we &&
        ((i_cfg_index == prgb_pkg::REG_RED_FULL_SCALE) ||
         (i_cfg_index == prgb_pkg::REG_GREEN_FULL_SCALE) ||
         (i_cfg_index == prgb_pkg::REG_BLUE_FULL_SCALE));

    assign w_gray_same = (o_out_data.gray_argb[23:16] == o_out_data.gray_argb[15:8]) &&
                         (o_out_data.gray_argb[15:8] == o_out_data.gray_argb[7:0]);

    `PRGB_ASSERT_SAME(a_alpha_opaque, i_clk, i_rst_n, o_out_valid, o_out_data.gray_argb[31:24] == prgb_pkg::ALPHA_OPAQUE)
    `PRGB_ASSERT_SAME(a_gray_bytes_equal, i_clk, i_rst_n, o_out_valid, w_gray_same)
    `PRGB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `PRGB_ASSERT_NEXT(a_rebuild_stalls, i_clk, i_rst_n, w_fs_write, o_in_stall)
    `PRGB_ASSERT_NEXT_ALWAYS(a_reset_stalls, i_clk, !i_rst_n, o_in_stall)

endmodule

bind packed_rgb_to_gray_argb_top prgb_checker u_prgb_checker (.*);
